@@ hdl/pgpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpc_pkg
// shared constants, types and the output rounding function
// ----------------------------------------------------------------------------
package pgpc_pkg;

    localparam int FRAC  = 16;               // fraction bits of the fixed point
    localparam int HPW   = 64;               // plane height product width
    localparam int HW    = HPW - FRAC;       // scaled plane height width
    localparam int CW    = HW + 1;           // compare width for local y
    localparam int DW    = 33;               // motion / divisor width
    localparam int PW    = 66;               // widest product
    localparam int NSTG  = FRAC;             // divider stages, one bit each

    localparam logic [FRAC:0] ONE = {1'b1, {FRAC{1'b0}}};

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_LOCAL  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_SCALE  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic               en;
        logic               local_mode;
        logic signed [31:0] height;
        logic        [30:0] scale;
    } t_cfg;

    // word carried along the divider and multiplier stages
    typedef struct packed {
        logic                  hit;
        logic signed [31:0]    vx;
        logic signed [31:0]    vy;
        logic signed [31:0]    vz;
        logic        [FRAC:0]  fr;
        logic signed [32:0]    opb;
        logic signed [DW-1:0]  dx;
        logic signed [DW-1:0]  dy;
        logic signed [DW-1:0]  dz;
    } t_item;

    // negate, floor by 2^FRAC and saturate to 32 bits
    function automatic logic signed [31:0] f_neg_sat(input logic signed [PW-1:0] p);
        logic signed [PW:0] n;
        logic signed [PW:0] s;
        n = -$signed({p[PW-1], p});
        s = n >>> FRAC;
        if (s[PW:31] == '0 || s[PW:31] == '1)
            return s[31:0];
        else
            return s[PW] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

endpackage

@@ hdl/pgpc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpc_front
// plane height product, local y, crossing test and divider operands
// ----------------------------------------------------------------------------
module pgpc_front import pgpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_cfg               i_cfg,
    input  logic               i_vld,
    input  logic signed [31:0] i_cur_x,
    input  logic signed [31:0] i_cur_y,
    input  logic signed [31:0] i_cur_z,
    input  logic signed [31:0] i_next_x,
    input  logic signed [31:0] i_next_y,
    input  logic signed [31:0] i_next_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_bounce,
    input  logic signed [31:0] i_friction,
    output logic               o_vld,
    output t_item              o_item,
    output logic [DW-1:0]      o_rem,
    output logic [DW-1:0]      o_den
);

    // stage a
    logic                  r_vld_a;
    t_item                 r_item_a;
    logic signed [HPW-1:0] r_hprod;
    logic signed [DW-1:0]  r_cl;
    logic signed [DW-1:0]  r_nl;
    logic                  r_en_a;

    logic signed [DW-1:0]  n_cl;
    logic signed [DW-1:0]  n_nl;
    logic        [FRAC:0]  n_fr;

    always_comb begin
        n_cl = DW'(i_cur_y);
        n_nl = DW'(i_next_y);
        if (i_cfg.local_mode) begin
            n_cl = DW'(i_cur_y) - DW'(i_center_y);
            n_nl = DW'(i_next_y) - DW'(i_center_y);
        end
        if (i_friction < 0)
            n_fr = '0;
        else if (i_friction > $signed(32'(ONE)))
            n_fr = ONE;
        else
            n_fr = i_friction[FRAC:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (i_adv) begin
            r_vld_a <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_hprod       <= HPW'(i_cfg.height) * $signed({1'b0, i_cfg.scale});
            r_cl          <= n_cl;
            r_nl          <= n_nl;
            r_en_a        <= i_cfg.en;
            r_item_a.hit  <= 1'b0;
            r_item_a.vx   <= i_vel_x;
            r_item_a.vy   <= i_vel_y;
            r_item_a.vz   <= i_vel_z;
            r_item_a.fr   <= n_fr;
            r_item_a.opb  <= 33'(i_bounce) + $signed(33'(ONE));
            r_item_a.dx   <= DW'(i_next_x) - DW'(i_cur_x);
            r_item_a.dy   <= DW'(i_next_y) - DW'(i_cur_y);
            r_item_a.dz   <= DW'(i_next_z) - DW'(i_cur_z);
        end
    end

    // stage b
    logic signed [HW-1:0] n_h;
    logic signed [CW-1:0] n_hx;
    logic signed [CW-1:0] n_clx;
    logic signed [CW-1:0] n_nlx;
    logic signed [CW-1:0] n_num;
    logic                 n_hit;
    t_item                n_item;

    always_comb begin
        n_h   = HW'(r_hprod >>> FRAC);
        n_hx  = CW'(n_h);
        n_clx = CW'(r_cl);
        n_nlx = CW'(r_nl);
        n_num = n_clx - n_hx;
        n_hit = r_en_a && (n_nlx < n_hx) && (n_clx >= n_hx) && (r_item_a.dy != '0);
        n_item     = r_item_a;
        n_item.hit = n_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_adv) begin
            o_vld <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_item <= n_item;
            o_rem  <= n_num[DW-1:0];
            o_den  <= DW'(-r_item_a.dy);
        end
    end

endmodule

@@ hdl/pgpc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpc_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module pgpc_div import pgpc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_vld,
    input  t_item           i_item,
    input  logic [DW-1:0]   i_rem,
    input  logic [DW-1:0]   i_den,
    output logic            o_vld,
    output t_item           o_item,
    output logic [FRAC-1:0] o_q
);

    logic            r_vld  [NSTG+1];
    t_item           r_item [NSTG+1];
    logic [DW-1:0]   r_rem  [NSTG+1];
    logic [DW-1:0]   r_den  [NSTG+1];
    logic [FRAC-1:0] r_q    [NSTG+1];

    always_comb begin
        r_vld[0]  = i_vld;
        r_item[0] = i_item;
        r_rem[0]  = i_rem;
        r_den[0]  = i_den;
        r_q[0]    = '0;
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        logic [DW:0] n_r2;
        logic        n_ge;
        logic [DW:0] n_diff;

        always_comb begin
            n_r2   = {r_rem[k], 1'b0};
            n_diff = n_r2 - {1'b0, r_den[k]};
            n_ge   = n_r2 >= {1'b0, r_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_item[k+1] <= r_item[k];
                r_den[k+1]  <= r_den[k];
                r_rem[k+1]  <= n_ge ? n_diff[DW-1:0] : n_r2[DW-1:0];
                r_q[k+1]    <= {r_q[k][FRAC-2:0], n_ge};
            end
        end
    end

    assign o_vld  = r_vld[NSTG];
    assign o_item = r_item[NSTG];
    assign o_q    = r_q[NSTG];

endmodule

@@ hdl/pgpc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpc_back
// velocity and offset products, then rounding, saturation and output word
// ----------------------------------------------------------------------------
module pgpc_back import pgpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_vld,
    input  t_item              i_item,
    input  logic [FRAC-1:0]    i_q,
    output logic               o_vld,
    output logic signed [31:0] o_dvel_x,
    output logic signed [31:0] o_dvel_y,
    output logic signed [31:0] o_dvel_z,
    output logic signed [31:0] o_dpos_x,
    output logic signed [31:0] o_dpos_y,
    output logic signed [31:0] o_dpos_z,
    output logic               o_collided
);

    logic                 r_vld_m;
    logic                 r_hit_m;
    logic signed [PW-1:0] r_pvx, r_pvy, r_pvz, r_pdx, r_pdy, r_pdz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m <= 1'b0;
            o_vld   <= 1'b0;
        end else if (i_adv) begin
            r_vld_m <= i_vld;
            o_vld   <= r_vld_m;
        end
    end

    // operands widen to the full product width through the assignment
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_hit_m <= i_item.hit;
            r_pvx   <= i_item.vx * $signed({1'b0, i_item.fr});
            r_pvy   <= i_item.vy * i_item.opb;
            r_pvz   <= i_item.vz * $signed({1'b0, i_item.fr});
            r_pdx   <= i_item.dx * $signed({1'b0, i_q});
            r_pdy   <= i_item.dy * $signed({1'b0, i_q});
            r_pdz   <= i_item.dz * $signed({1'b0, i_q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_collided <= r_hit_m;
            o_dvel_x   <= r_hit_m ? f_neg_sat(r_pvx) : '0;
            o_dvel_y   <= r_hit_m ? f_neg_sat(r_pvy) : '0;
            o_dvel_z   <= r_hit_m ? f_neg_sat(r_pvz) : '0;
            o_dpos_x   <= r_hit_m ? f_neg_sat(r_pdx) : '0;
            o_dpos_y   <= r_hit_m ? f_neg_sat(r_pdy) : '0;
            o_dpos_z   <= r_hit_m ? f_neg_sat(r_pdz) : '0;
        end
    end

endmodule

@@ hdl/particle_ground_plane_collision.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_ground_plane_collision
// ground plane collision response for a stream of particles
// ----------------------------------------------------------------------------
// usage
//   input channel i_valid / o_ready moves one particle word per accept:
//   positions, velocity, center height, bounce and friction
//   output channel o_valid / i_ready moves one result word per particle:
//   velocity change, position offset and the collided flag
//   configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data),
//   to be written by the user only while no particle is in flight; the
//   block itself does not enforce this
//   throughput is one word per cycle while the receiver does not stall;
//   the one-bit-per-stage divider forms the crossing rate
//   reset clears all stage valid bits and loads the register defaults
//   (disabled, global mode, height 0, scale 1.0)
//   when the receiver stalls the whole pipeline holds; o_ready follows
//   the output register, so nothing is lost or repeated
// ----------------------------------------------------------------------------
module particle_ground_plane_collision import pgpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_cur_x,
    input  logic signed [31:0] i_cur_y,
    input  logic signed [31:0] i_cur_z,
    input  logic signed [31:0] i_next_x,
    input  logic signed [31:0] i_next_y,
    input  logic signed [31:0] i_next_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_bounce,
    input  logic signed [31:0] i_friction,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_dvel_x,
    output logic signed [31:0] o_dvel_y,
    output logic signed [31:0] o_dvel_z,
    output logic signed [31:0] o_dpos_x,
    output logic signed [31:0] o_dpos_y,
    output logic signed [31:0] o_dpos_z,
    output logic               o_collided
);

    t_cfg r_cfg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.en         <= 1'b0;
            r_cfg.local_mode <= 1'b0;
            r_cfg.height     <= '0;
            r_cfg.scale      <= 31'(ONE);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ENABLE: r_cfg.en         <= i_cfg_data[0];
                REG_LOCAL:  r_cfg.local_mode <= i_cfg_data[0];
                REG_HEIGHT: r_cfg.height     <= i_cfg_data;
                REG_SCALE:  r_cfg.scale      <= i_cfg_data[30:0];
                default:    ;
            endcase
        end
    end

    // whole pipeline advances unless a finished word is stuck at the output
    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    logic            fr_vld;
    t_item           fr_item;
    logic [DW-1:0]   fr_rem;
    logic [DW-1:0]   fr_den;
    logic            dv_vld;
    t_item           dv_item;
    logic [FRAC-1:0] dv_q;

    // height product, local y, crossing test
    pgpc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_cfg      (r_cfg),
        .i_vld      (i_valid),
        .i_cur_x    (i_cur_x),
        .i_cur_y    (i_cur_y),
        .i_cur_z    (i_cur_z),
        .i_next_x   (i_next_x),
        .i_next_y   (i_next_y),
        .i_next_z   (i_next_z),
        .i_vel_x    (i_vel_x),
        .i_vel_y    (i_vel_y),
        .i_vel_z    (i_vel_z),
        .i_center_y (i_center_y),
        .i_bounce   (i_bounce),
        .i_friction (i_friction),
        .o_vld      (fr_vld),
        .o_item     (fr_item),
        .o_rem      (fr_rem),
        .o_den      (fr_den)
    );

    // crossing rate: (cur - h) * 2^FRAC / |dy|
    pgpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (fr_vld),
        .i_item  (fr_item),
        .i_rem   (fr_rem),
        .i_den   (fr_den),
        .o_vld   (dv_vld),
        .o_item  (dv_item),
        .o_q     (dv_q)
    );

    // products, rounding, saturation, output register
    pgpc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_vld      (dv_vld),
        .i_item     (dv_item),
        .i_q        (dv_q),
        .o_vld      (o_valid),
        .o_dvel_x   (o_dvel_x),
        .o_dvel_y   (o_dvel_y),
        .o_dvel_z   (o_dvel_z),
        .o_dpos_x   (o_dpos_x),
        .o_dpos_y   (o_dpos_y),
        .o_dpos_z   (o_dpos_z),
        .o_collided (o_collided)
    );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// ground plane collision: streams particle words through the block under
// random idling on both sides, predicts each result word in wide signed
// arithmetic and compares every field in order of arrival
// ----------------------------------------------------------------------------
module testbench import pgpc_pkg::*; ();

    localparam int LATENCY   = FRAC + 4;
    localparam int MAX_CYCLE = 400000;

    // one particle word and one result word
    typedef struct {
        logic signed [31:0] cx, cy, cz, nx, ny, nz, vx, vy, vz, cen, bnc, fr;
    } t_particle;

    typedef struct {
        logic signed [31:0] dvx, dvy, dvz, dpx, dpy, dpz;
        logic               hit;
    } t_response;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_cur_x = '0, i_cur_y = '0, i_cur_z = '0;
    logic signed [31:0] i_next_x = '0, i_next_y = '0, i_next_z = '0;
    logic signed [31:0] i_vel_x = '0, i_vel_y = '0, i_vel_z = '0;
    logic signed [31:0] i_center_y = '0, i_bounce = '0, i_friction = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_dvel_x, o_dvel_y, o_dvel_z;
    logic signed [31:0] o_dpos_x, o_dpos_y, o_dpos_z;
    logic               o_collided;

    particle_ground_plane_collision dut (.*);

    // predictor's own copy of the registers
    logic               gp_enable = 1'b0;
    logic               gp_local  = 1'b0;
    logic signed [31:0] gp_height = '0;
    logic        [30:0] gp_scale  = 31'h10000;

    t_response responses_due[$];
    int        mismatch_count = 0;
    int        response_count = 0;
    int        collision_count = 0;
    longint    cycle_count = 0;
    bit        quiet_idle = 1'b0;     // long stretch with no idling

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // floor by 2^FRAC then saturate to 32 bits
    function automatic logic signed [31:0] floor_sat(input logic signed [127:0] p);
        logic signed [127:0] s;
        s = p >>> FRAC;
        if (s > 128'sd2147483647) return 32'sh7fff_ffff;
        if (s < -128'sd2147483648) return 32'sh8000_0000;
        return s[31:0];
    endfunction

    function automatic t_response predict_bounce(input t_particle p);
        t_response r;
        logic signed [127:0] h, cl, nl, dy, dx, dz, num, q, fr, one;
        r = '{default: '0};
        if (!gp_enable) return r;
        one = 128'sd1 <<< FRAC;
        h  = ($signed(128'(gp_height)) * $signed({97'd0, gp_scale})) >>> FRAC;
        cl = p.cy;
        nl = p.ny;
        if (gp_local) begin
            cl = cl - p.cen;
            nl = nl - p.cen;
        end
        dy = 128'(p.ny) - 128'(p.cy);
        if (!(nl < h && cl >= h && dy != 0)) return r;
        num = cl - h;
        q  = (num <<< FRAC) / (-dy);
        dx = 128'(p.nx) - 128'(p.cx);
        dz = 128'(p.nz) - 128'(p.cz);
        fr = p.fr;
        if (fr < 0) fr = 0;
        if (fr > one) fr = one;
        r.dvx = floor_sat(-(128'(p.vx) * fr));
        r.dvy = floor_sat(-(128'(p.vy) * (one + 128'(p.bnc))));
        r.dvz = floor_sat(-(128'(p.vz) * fr));
        r.dpx = floor_sat(-(dx * q));
        r.dpy = floor_sat(-(dy * q));
        r.dpz = floor_sat(-(dz * q));
        r.hit = 1'b1;
        return r;
    endfunction

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver: random stalls, compare at accept
    always @(posedge i_clk) begin
        t_response e;
        if (i_rst_n && o_valid && i_ready) begin
            response_count <= response_count + 1;
            if (responses_due.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) $display("unexpected result word");
            end else begin
                e = responses_due.pop_front();
                if (o_collided) collision_count <= collision_count + 1;
                if (e.dvx !== o_dvel_x || e.dvy !== o_dvel_y || e.dvz !== o_dvel_z ||
                    e.dpx !== o_dpos_x || e.dpy !== o_dpos_y || e.dpz !== o_dpos_z ||
                    e.hit !== o_collided) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display({"mismatch: exp dv %h %h %h dp %h %h %h c %b",
                                  " / got %h %h %h %h %h %h %b"},
                            e.dvx, e.dvy, e.dvz, e.dpx, e.dpy, e.dpz, e.hit,
                            o_dvel_x, o_dvel_y, o_dvel_z, o_dpos_x, o_dpos_y, o_dpos_z,
                            o_collided);
                end
            end
        end
        i_ready <= quiet_idle ? 1'b1 : ($urandom_range(99) >= 9);
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ENABLE: gp_enable = value[0];
            REG_LOCAL:  gp_local  = value[0];
            REG_HEIGHT: gp_height = value;
            REG_SCALE:  gp_scale  = value[30:0];
            default:    ;
        endcase
    endtask

    // wait for every result and then the pipeline depth
    task automatic drain_block();
        while (responses_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic configure(input bit en, input bit loc, input logic [31:0] height,
                             input logic [31:0] scale);
        drain_block();
        write_reg(REG_ENABLE, {31'd0, en});
        write_reg(REG_LOCAL, {31'd0, loc});
        write_reg(REG_HEIGHT, height);
        write_reg(REG_SCALE, scale);
    endtask

    // present one particle word, hold until accepted
    task automatic send_particle(input t_particle p);
        while (!quiet_idle && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cur_x <= p.cx;  i_cur_y <= p.cy;  i_cur_z <= p.cz;
        i_next_x <= p.nx; i_next_y <= p.ny; i_next_z <= p.nz;
        i_vel_x <= p.vx;  i_vel_y <= p.vy;  i_vel_z <= p.vz;
        i_center_y <= p.cen; i_bounce <= p.bnc; i_friction <= p.fr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        responses_due.push_back(predict_bounce(p));
    endtask

    task automatic finish_send();
        i_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'sh8000_0000 | $urandom_range(3);
            1: return 32'sh7fff_fffc | $urandom_range(3);
            2: return $signed($urandom_range(65536)) - 32768;
            3: return $signed($urandom_range(1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    // mostly a downward crossing of the current plane, with random content
    function automatic t_particle crossing_particle();
        t_particle p;
        logic signed [63:0] h, base;
        p.cx = rand_word(); p.cz = rand_word();
        p.nx = rand_word(); p.nz = rand_word();
        p.vx = rand_word(); p.vy = rand_word(); p.vz = rand_word();
        p.bnc = rand_word();
        case ($urandom_range(3))
            0: p.fr = rand_word();
            default: p.fr = $urandom_range(65536);
        endcase
        p.cen = ($urandom_range(1)) ? rand_word() : $signed($urandom_range(1 << 18)) - (1 << 17);
        h = (64'(gp_height) * $signed({33'd0, gp_scale})) >>> FRAC;
        base = h + (gp_local ? 64'(p.cen) : 64'sd0);
        if ($urandom_range(9) < 8 && base > -64'sd2000000000 && base < 64'sd2000000000) begin
            p.cy = base + $urandom_range(1 << $urandom_range(24));
            p.ny = base - 1 - $urandom_range(1 << $urandom_range(24));
        end else begin
            p.cy = rand_word();
            p.ny = rand_word();
        end
        return p;
    endfunction

    task automatic test_directed();
        t_particle p;
        // disabled after reset
        p = '{default: 32'sh0001_0000};
        p.ny = -32'sh0001_0000;
        send_particle(p);
        finish_send();
        configure(1'b1, 1'b0, 32'sd0, 32'h10000);
        // plain crossing, exact touch at the plane, upward, no motion
        send_particle(p);
        p.cy = 0; send_particle(p);
        p.cy = -32'sh10000; p.ny = 32'sh10000; send_particle(p);
        p.cy = 5; p.ny = 5; send_particle(p);
        // extremes of every field, friction above one and below zero
        p = '{default: 32'sh7fff_ffff};
        p.ny = 32'sh8000_0000; p.bnc = 32'sh7fff_ffff; send_particle(p);
        p = '{default: 32'sh8000_0000};
        p.cy = 32'sh7fff_ffff; p.fr = 32'sh8000_0000; send_particle(p);
        p.fr = 32'sh0000_8000; p.vx = 32'sh7fff_ffff; send_particle(p);
        p.fr = 32'sh0002_0000; p.bnc = -32'sh10000; send_particle(p);
        p.fr = 32'sh0000_0000; p.bnc = 32'sh8000_0000; send_particle(p);
        p.fr = 32'sh0001_0000; p.bnc = 32'sh0000_0000; send_particle(p);
        p.fr = 32'sh0001_0001; p.bnc = 32'sh7fff_ffff; send_particle(p);
        finish_send();
        // local mode with extreme center and plane settings
        configure(1'b1, 1'b1, 32'sh8000_0000, 32'h7fff_ffff);
        p = '{default: 32'sh1234_5678};
        p.cen = 32'sh8000_0000; p.cy = 32'sh7fff_ffff; p.ny = 32'sh8000_0000;
        send_particle(p);
        p.cen = 32'sh7fff_ffff; send_particle(p);
        finish_send();
        configure(1'b1, 1'b1, 32'sh7fff_ffff, 32'h0);
        p.cen = 32'sh0001_0000; p.cy = 32'sh0002_0000; p.ny = 32'sh0000_0001;
        send_particle(p);
        finish_send();
        configure(1'b1, 1'b0, 32'sh7fff_ffff, 32'h7fff_ffff);
        send_particle(p);
        finish_send();
    endtask

    task automatic test_random_phase(input int count);
        repeat (count) send_particle(crossing_particle());
        finish_send();
    endtask

    task automatic test_random_settings();
        int unsigned kind;
        for (int phase = 0; phase < 12; phase++) begin
            kind = $urandom_range(3);
            configure(phase != 3, $urandom_range(1),
                      kind == 0 ? 32'h8000_0000 : kind == 1 ? 32'h7fff_ffff :
                                  $signed($urandom_range(1 << 22)) - (1 << 21),
                      kind == 2 ? 32'h7fff_ffff : ($urandom_range(1) ? 32'h10000 :
                                  $urandom_range(1 << 18)));
            quiet_idle = (phase == 5);
            test_random_phase(100);
            quiet_idle = 1'b0;
        end
    endtask

    // sender holds off until the pipeline has fully emptied
    task automatic test_hold_off();
        configure(1'b1, 1'b0, 32'sh0000_8000, 32'h0002_0000);
        test_random_phase(30);
        while (responses_due.size() != 0) @(posedge i_clk);
        test_random_phase(30);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_hold_off();
        test_random_settings();
        drain_block();
        $display("covered %0d result words, %0d collisions, reset defaults and 17 written",
                 response_count, collision_count);
        $display("register settings, with stalls on both sides and one full drain");
        if (mismatch_count == 0 && responses_due.size() == 0)
            $display("testbench: clean");
        else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     responses_due.size());
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
